// File: rtl/sbmq_pkg.sv
// Shared types, sizes and codes for the shared-buffer multi-queue unit.
`timescale 1ns / 1ps

package sbmq_pkg;

	// Sizes
	localparam int SLOT_COUNT  = 256;
	localparam int QUEUE_COUNT = 8;
	localparam int DATA_WIDTH  = 32;
	localparam int SLOT_W      = $clog2(SLOT_COUNT);
	localparam int PTR_W       = SLOT_W + 1;
	localparam int QID_W       = 3;
	localparam int XFER_W      = 32;

	// Pointer value that marks the end of a chain or an empty queue
	localparam logic [PTR_W-1:0] END_MARK = PTR_W'(SLOT_COUNT);

	typedef enum logic {
		OP_ENQ = 1'b0,
		OP_DEQ = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		STAT_DONE    = 2'd0,
		STAT_NO_SLOT = 2'd1,
		STAT_EMPTY   = 2'd2
	} status_t;

	typedef struct packed {
		opcode_t            opcode;
		logic [QID_W-1:0]   queue_id;
		logic signed [31:0] write_data;
	} req_item_t;

	typedef struct packed {
		status_t            status;
		logic signed [31:0] read_data;
	} rsp_item_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic accept;  // latch item, issue store reads
		logic exec;    // commit store writes, load result register
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic out_free;  // result register empty or being taken this cycle
	} sts_t;

endpackage

// File: rtl/shared_buffer_multi_queue_unit.sv
// Top level of the shared-buffer multi-queue unit.
// An accepted item waits in S_EXEC; its execute step loads the result register,
// held off only while the result register is still held by rsp_stall.
// One item at a time: input stalls while an item is in work (link store read, then write).
// Reset: all queues empty, free list at slot 0 chaining every slot in order;
// link valid bits clear at once, so no clearing pass is needed.
`timescale 1ns / 1ps

module shared_buffer_multi_queue_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  sbmq_pkg::req_item_t req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output sbmq_pkg::rsp_item_t rsp
);
	import sbmq_pkg::*;

	cmd_t cmd;
	sts_t sts;

	sbmq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	sbmq_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// Execute never overwrites a result still held by the sink
	a_exec_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> !(rsp_valid && rsp_stall))
		else $error("execute while result register is blocked");

	// An execute always presents a result on the next cycle
	a_exec_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> rsp_valid)
		else $error("result missing after execute");

	// An accepted item blocks the input until it has executed
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("input open while an item is in work");

	// Accept and execute never coincide
	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.accept && cmd.exec))
		else $error("accept and execute in the same cycle");

endmodule

// File: rtl/sbmq_ctrl.sv
// Controller state machine: sequences accept and execute of each item.
`timescale 1ns / 1ps

module sbmq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  sbmq_pkg::sts_t sts,
	output sbmq_pkg::cmd_t cmd
);
	import sbmq_pkg::*;

	state_t state_q;
	state_t state_nx;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Next state and commands
	always_comb begin
		state_nx   = state_q;
		req_stall  = 1'b1;
		cmd.accept = 1'b0;
		cmd.exec   = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.accept = 1'b1;
					state_nx   = S_EXEC;
				end
			end
			S_EXEC: begin
				// wait until the result register can take the result
				if (sts.out_free) begin
					cmd.exec = 1'b1;
					state_nx = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

endmodule

// File: rtl/sbmq_dpath.sv
// Datapath: slot stores, queue pointers, free list and result register.
`timescale 1ns / 1ps

module sbmq_dpath (
	input  logic                clk,
	input  logic                arst_n,
	input  sbmq_pkg::req_item_t req,
	input  sbmq_pkg::cmd_t      cmd,
	output sbmq_pkg::sts_t      sts,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output sbmq_pkg::rsp_item_t rsp
);
	import sbmq_pkg::*;

	// Slot stores
	logic [DATA_WIDTH-1:0] data_mem [SLOT_COUNT];
	logic [PTR_W-1:0]      link_mem [SLOT_COUNT];
	// link entry has been written; unwritten entries read as slot + 1
	logic [SLOT_COUNT-1:0] lvld_q;

	// Queue and free-list pointers
	logic [PTR_W-1:0] head_q [QUEUE_COUNT];
	logic [PTR_W-1:0] tail_q [QUEUE_COUNT];
	logic [PTR_W-1:0] free_q;

	// Item latched at accept
	opcode_t               op_q;
	logic [QID_W-1:0]      qid_q;
	logic [DATA_WIDTH-1:0] wdata_q;
	logic [SLOT_W-1:0]     slot_q;
	logic                  slot_ok_q;

	// Registered store reads
	logic [PTR_W-1:0]      link_rd_q;
	logic                  lvld_rd_q;
	logic [DATA_WIDTH-1:0] data_rd_q;

	// Result register
	logic      rsp_valid_q;
	rsp_item_t rsp_q;

	logic [PTR_W-1:0]  sel_ptr;
	logic [SLOT_W-1:0] sel_addr;
	logic [PTR_W-1:0]  link_nx;
	logic [PTR_W-1:0]  cur_head;
	logic [PTR_W-1:0]  cur_tail;
	logic              qid_ok;
	logic              head_live;
	logic              do_enq;
	logic              do_deq;
	logic              lwr_en;
	logic [SLOT_W-1:0] lwr_addr;
	logic [PTR_W-1:0]  lwr_data;

	// Pointer that the incoming item works on
	always_comb begin
		sel_ptr  = (req.opcode == OP_ENQ) ? free_q : head_q[req.queue_id];
		sel_addr = sel_ptr[SLOT_W-1:0];
	end

	// Latch item at accept
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q      <= req.opcode;
			qid_q     <= req.queue_id;
			wdata_q   <= DATA_WIDTH'(req.write_data);
			slot_q    <= sel_addr;
			slot_ok_q <= (sel_ptr < END_MARK);
			lvld_rd_q <= lvld_q[sel_addr];
		end
	end

	// Execute-step decode
	always_comb begin
		cur_head  = head_q[qid_q];
		cur_tail  = tail_q[qid_q];
		qid_ok    = (int'(qid_q) < QUEUE_COUNT);
		head_live = (cur_head < END_MARK);
		link_nx   = lvld_rd_q ? link_rd_q : ({1'b0, slot_q} + PTR_W'(1));
		do_enq    = cmd.exec && (op_q == OP_ENQ) && qid_ok && slot_ok_q;
		do_deq    = cmd.exec && (op_q == OP_DEQ) && qid_ok && slot_ok_q;
		lwr_en    = 1'b0;
		lwr_addr  = slot_q;
		lwr_data  = free_q;
		if (do_enq && head_live) begin
			// append behind the current tail
			lwr_en   = 1'b1;
			lwr_addr = cur_tail[SLOT_W-1:0];
			lwr_data = {1'b0, slot_q};
		end else if (do_deq) begin
			// push freed slot on the free-list head
			lwr_en   = 1'b1;
			lwr_addr = slot_q;
			lwr_data = free_q;
		end
	end

	// Link store: read at accept, write at execute
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			link_rd_q <= link_mem[sel_addr];
		end
		if (lwr_en) begin
			link_mem[lwr_addr] <= lwr_data;
		end
	end

	// Data store: read at accept, write at execute
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			data_rd_q <= data_mem[sel_addr];
		end
		if (do_enq) begin
			data_mem[slot_q] <= wdata_q;
		end
	end

	// Pointers and link valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < QUEUE_COUNT; i++) begin
				head_q[i] <= END_MARK;
				tail_q[i] <= END_MARK;
			end
			free_q <= '0;
			lvld_q <= '0;
		end else begin
			if (lwr_en) begin
				lvld_q[lwr_addr] <= 1'b1;
			end
			if (do_enq) begin
				free_q        <= link_nx;
				tail_q[qid_q] <= {1'b0, slot_q};
				if (!head_live) begin
					head_q[qid_q] <= {1'b0, slot_q};
				end
			end
			if (do_deq) begin
				free_q        <= {1'b0, slot_q};
				// last slot of the queue: tail link is not kept
				head_q[qid_q] <= (cur_head == cur_tail) ? END_MARK : link_nx;
			end
		end
	end

	// Result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.exec) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if (do_enq || do_deq) begin
				rsp_q.status <= STAT_DONE;
			end else if (op_q == OP_ENQ) begin
				rsp_q.status <= STAT_NO_SLOT;
			end else begin
				rsp_q.status <= STAT_EMPTY;
			end
			if (do_deq) begin
				rsp_q.read_data <= XFER_W'(data_rd_q);
			end else begin
				rsp_q.read_data <= '0;
			end
		end
	end

	assign sts.out_free = !rsp_valid_q || !rsp_stall;
	assign rsp_valid    = rsp_valid_q;
	assign rsp          = rsp_q;

endmodule

// File: verif/tb_shared_buffer_multi_queue_unit.sv
// Testbench for the shared-buffer multi-queue unit: directed and random traffic checked against a predictor.
`timescale 1ns / 1ps

module tb_shared_buffer_multi_queue_unit;
	import sbmq_pkg::*;

	localparam int IDLE_LIMIT  = 3000;
	localparam int RANDOM_ITEMS = 380;
	localparam int SHOW_LIMIT  = 40;

	// Predicts the queue contents and holds the results still owed by the block
	class shared_queue_predictor;
		logic [31:0]      slot_val [SLOT_COUNT];
		logic [PTR_W-1:0] slot_next [SLOT_COUNT];
		logic [PTR_W-1:0] q_first [QUEUE_COUNT];
		logic [PTR_W-1:0] q_last [QUEUE_COUNT];
		logic [PTR_W-1:0] free_ptr;
		int               q_len [QUEUE_COUNT];
		int               used;
		int               peak;
		rsp_item_t        owed_results[$];
		int               errors;
		int               n_items, n_stored, n_taken, n_full, n_empty;

		function new();
			for (int i = 0; i < SLOT_COUNT; i++) begin
				slot_val[i] = '0;
				slot_next[i] = (i == SLOT_COUNT - 1) ? END_MARK : PTR_W'(i + 1);
			end
			for (int i = 0; i < QUEUE_COUNT; i++) begin
				q_first[i] = END_MARK;
				q_last[i] = END_MARK;
				q_len[i] = 0;
			end
			free_ptr = '0;
			used = 0;
			peak = 0;
			errors = 0;
			n_items = 0;
			n_stored = 0;
			n_taken = 0;
			n_full = 0;
			n_empty = 0;
		endfunction

		function bit is_slot(logic [PTR_W-1:0] p);
			return p < PTR_W'(SLOT_COUNT);
		endfunction

		// Apply one accepted item to the predicted state and queue its result
		function void note_request(req_item_t it);
			rsp_item_t        r;
			logic [PTR_W-1:0] s;
			logic [QID_W-1:0] q;
			q = it.queue_id;
			r.status = STAT_DONE;
			r.read_data = '0;
			n_items++;
			if (it.opcode == OP_ENQ) begin
				if (!is_slot(free_ptr)) begin
					r.status = STAT_NO_SLOT;
					n_full++;
				end else begin
					s = free_ptr;
					free_ptr = slot_next[s[SLOT_W-1:0]];
					if (!is_slot(q_first[q]))
						q_first[q] = s;
					else if (is_slot(q_last[q]))
						slot_next[q_last[q][SLOT_W-1:0]] = s;
					slot_next[s[SLOT_W-1:0]] = END_MARK;
					q_last[q] = s;
					slot_val[s[SLOT_W-1:0]] = it.write_data;
					q_len[q]++;
					used++;
					if (used > peak)
						peak = used;
					n_stored++;
				end
			end else begin
				if (!is_slot(q_first[q])) begin
					r.status = STAT_EMPTY;
					n_empty++;
				end else begin
					s = q_first[q];
					q_first[q] = slot_next[s[SLOT_W-1:0]];
					slot_next[s[SLOT_W-1:0]] = free_ptr;
					free_ptr = s;
					r.read_data = slot_val[s[SLOT_W-1:0]];
					q_len[q]--;
					used--;
					n_taken++;
				end
			end
			owed_results.insert(owed_results.size(), r);
		endfunction

		task report(string msg);
			if (errors < SHOW_LIMIT)
				$display("[%0t] MISMATCH: %s", $time, msg);
			errors++;
		endtask

		// Compare one accepted result with the oldest owed one
		task check_response(rsp_item_t got);
			rsp_item_t want;
			if (owed_results.size() == 0) begin
				report($sformatf("result with nothing owed: status %0d data %h",
					got.status, got.read_data));
			end else begin
				want = owed_results.pop_front();
				if (got.status !== want.status)
					report($sformatf("status %0d, predicted %0d", got.status, want.status));
				if (got.read_data !== want.read_data)
					report($sformatf("read_data %h, predicted %h",
						got.read_data, want.read_data));
			end
		endtask
	endclass

	typedef enum int {
		PH_FILL,
		PH_MIX
	} phase_t;

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_stall;
	req_item_t req;
	logic      rsp_valid;
	logic      rsp_stall;
	rsp_item_t rsp;

	shared_queue_predictor sb;
	int                    idle_cycles = 0;
	bit                    req_calm;
	bit                    rsp_calm;

	shared_buffer_multi_queue_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Mostly short gaps, a few long ones, none in calm stretches
	function automatic int pick_gap(bit calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Data with the field extremes mixed in
	function automatic logic [31:0] pick_data();
		case ($urandom_range(0, 19))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h7FFF_FFFF;
			3: return 32'h8000_0000;
			default: return $urandom;
		endcase
	endfunction

	// A queue that holds something, if any does
	function automatic logic [QID_W-1:0] pick_busy_queue();
		int start;
		start = $urandom_range(0, QUEUE_COUNT - 1);
		for (int i = 0; i < QUEUE_COUNT; i++)
			if (sb.q_len[(start + i) % QUEUE_COUNT] > 0)
				return QID_W'((start + i) % QUEUE_COUNT);
		return QID_W'(start);
	endfunction

	// Present one item, hold it until taken, then maybe idle
	task automatic send_item(opcode_t op, logic [QID_W-1:0] qid, logic [31:0] data);
		req_item_t it;
		int        gap;
		it.opcode = op;
		it.queue_id = qid;
		it.write_data = data;
		req <= it;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (req_stall);
		@(negedge clk);
		gap = pick_gap(req_calm);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Result-side back-pressure
	initial begin
		int n;
		rsp_stall = 1'b0;
		rsp_calm = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 15) == 0)
				rsp_calm = ($urandom_range(0, 2) == 0);
			n = pick_gap(rsp_calm);
			if (n > 0) begin
				rsp_stall <= 1'b1;
				repeat (n) @(negedge clk);
				rsp_stall <= 1'b0;
			end
			repeat ($urandom_range(0, 6)) @(negedge clk);
		end
	end

	// Handshake monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall)
				sb.note_request(req);
			if (rsp_valid && !rsp_stall)
				sb.check_response(rsp);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	// Watchdog on cycles with no handshake
	initial begin
		@(posedge arst_n);
		while (idle_cycles < IDLE_LIMIT)
			@(posedge clk);
		$display("timeout after %0d cycles with no handshake", IDLE_LIMIT);
		$display("end of test: mismatches");
		$finish;
	end

	// Stimulus
	initial begin
		phase_t phase;
		int     n_rand;
		int     extra;
		bit     deq;
		sb = new();
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		req_calm = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty queues, field extremes, emptied queue reused (stale tail)
		send_item(OP_DEQ, 3'd0, 32'h1234_5678);
		send_item(OP_DEQ, 3'd7, 32'hFFFF_FFFF);
		send_item(OP_ENQ, 3'd0, 32'h7FFF_FFFF);
		send_item(OP_ENQ, 3'd0, 32'h8000_0000);
		send_item(OP_ENQ, 3'd7, 32'h0000_0000);
		send_item(OP_ENQ, 3'd7, 32'hFFFF_FFFF);
		send_item(OP_ENQ, 3'd3, 32'h5555_5555);
		send_item(OP_ENQ, 3'd3, 32'hAAAA_AAAA);
		send_item(OP_DEQ, 3'd0, 32'h0);
		send_item(OP_DEQ, 3'd0, 32'h0);
		send_item(OP_DEQ, 3'd7, 32'h0);
		send_item(OP_DEQ, 3'd3, 32'h0);
		send_item(OP_DEQ, 3'd3, 32'h0);
		send_item(OP_ENQ, 3'd3, 32'h0000_04D2);
		send_item(OP_ENQ, 3'd3, 32'h0000_0005);
		send_item(OP_DEQ, 3'd3, 32'h0);
		send_item(OP_DEQ, 3'd3, 32'h0);
		send_item(OP_DEQ, 3'd3, 32'h0);
		send_item(OP_DEQ, 3'd7, 32'h0);
		send_item(OP_DEQ, 3'd7, 32'h0);
		send_item(OP_DEQ, 3'd0, 32'h0);

		// Random: fill the store past full, then mixed traffic
		phase = PH_FILL;
		n_rand = 0;
		extra = 0;
		while (!(phase == PH_MIX && n_rand >= RANDOM_ITEMS)) begin
			if (n_rand % 32 == 0)
				req_calm = ($urandom_range(0, 3) == 0);
			case (phase)
				PH_FILL: deq = ($urandom_range(0, 19) == 0);
				default: deq = $urandom_range(0, 1);
			endcase
			if (deq)
				send_item(OP_DEQ,
					($urandom_range(0, 4) != 0) ? pick_busy_queue() : QID_W'($urandom),
					$urandom);
			else
				send_item(OP_ENQ, QID_W'($urandom), pick_data());
			n_rand++;
			if (phase == PH_FILL && sb.used == SLOT_COUNT && ++extra >= 4)
				phase = PH_MIX;
		end
		req_valid <= 1'b0;

		// Let the last results drain
		while (sb.owed_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		$display("%0d items: %0d stored, %0d taken, %0d refused full, %0d refused empty",
			sb.n_items, sb.n_stored, sb.n_taken, sb.n_full, sb.n_empty);
		$display("peak occupancy %0d of %0d slots, %0d mismatches",
			sb.peak, SLOT_COUNT, sb.errors);
		if (sb.errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
